### rtl/ipmbv_pkg.sv
// Package for the IPMB frame validator: item structs, status and repair codes,
// frame state struct and size limits. No dependencies.
package ipmbv_pkg;

  localparam int MIN_FRAME = 6;
  localparam int MAX_FRAME = 255;
  localparam logic [6:0] OWN_ADDRESS_RESET = 7'd16;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_TOO_SHORT   = 3'd1,
    ST_HEADER_BAD  = 3'd2,
    ST_REPAIR_FAIL = 3'd3,
    ST_DATA_BAD    = 3'd4,
    ST_OVERSIZE    = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    RK_NONE     = 2'd0,
    RK_REPLACED = 2'd1,
    RK_INSERTED = 2'd2
  } repair_kind_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } byte_item_t;

  typedef struct packed {
    status_t      status;
    logic         is_response;
    logic [5:0]   net_function;
    repair_kind_t repair_kind;
    logic [7:0]   frame_length;
  } verdict_item_t;

  typedef struct packed {
    logic [8:0] byte_count;
    logic [7:0] hdr0;
    logic [7:0] hdr1;
    logic [7:0] hdr2;
    logic [7:0] sum_from_two;
    logic [7:0] sum_from_three;
  } frame_state_t;

endpackage

### rtl/ipmbv_accum.sv
// Running frame state: byte count, first three header bytes and the two
// data checksum sums. Depends on ipmbv_pkg.
module ipmbv_accum
  import ipmbv_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         step,
  input  byte_item_t   item,
  output frame_state_t frame
);

  frame_state_t frame_next;

  always_comb begin
    frame_next = frame;
    if (step) begin
      if (item.last_byte) begin
        frame_next = '0;
      end else begin
        if (frame.byte_count != 9'd511) begin
          frame_next.byte_count = frame.byte_count + 9'd1;
        end
        case (frame.byte_count)
          9'd0: frame_next.hdr0 = item.data_byte;
          9'd1: frame_next.hdr1 = item.data_byte;
          9'd2: frame_next.hdr2 = item.data_byte;
          default: ;
        endcase
        if (frame.byte_count >= 9'd2) begin
          frame_next.sum_from_two = frame.sum_from_two + item.data_byte;
        end
        if (frame.byte_count >= 9'd3) begin
          frame_next.sum_from_three = frame.sum_from_three + item.data_byte;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame <= '0;
    end else begin
      frame <= frame_next;
    end
  end

endmodule

### rtl/ipmbv_verdict.sv
// Verdict logic for the last byte of a frame: size checks, header checksum
// with address repair, and data checksum. Depends on ipmbv_pkg.
module ipmbv_verdict
  import ipmbv_pkg::*;
(
  input  frame_state_t  frame,
  input  logic [7:0]    data_byte,
  input  logic [6:0]    own_address,
  output verdict_item_t verdict
);

  logic [8:0] cnt;
  logic [7:0] addr;
  logic [7:0] nf_byte;
  logic [7:0] data_sum;
  logic       header_ok;
  repair_kind_t kind;

  always_comb begin
    cnt       = (frame.byte_count != 9'd511) ? frame.byte_count + 9'd1 : 9'd511;
    addr      = {own_address, 1'b0};
    header_ok = 1'b0;
    kind      = RK_NONE;
    nf_byte   = 8'd0;
    data_sum  = 8'd0;

    verdict              = '0;
    verdict.status       = ST_OK;
    verdict.repair_kind  = RK_NONE;
    verdict.frame_length = (cnt > 9'd255) ? 8'd255 : cnt[7:0];

    if (cnt > 9'(MAX_FRAME)) begin
      verdict.status = ST_OVERSIZE;
    end else if (cnt < 9'(MIN_FRAME)) begin
      verdict.status = ST_TOO_SHORT;
    end else begin
      if (8'(frame.hdr0 + frame.hdr1 + frame.hdr2) == 8'd0) begin
        header_ok = 1'b1;
        nf_byte   = frame.hdr1;
      end else if (frame.hdr0 == addr) begin
        verdict.status = ST_HEADER_BAD;
      end else if (8'(addr + frame.hdr1 + frame.hdr2) == 8'd0) begin
        header_ok = 1'b1;
        kind      = RK_REPLACED;
        nf_byte   = frame.hdr1;
      end else if (8'(addr + frame.hdr0 + frame.hdr1) == 8'd0) begin
        header_ok = 1'b1;
        kind      = RK_INSERTED;
        nf_byte   = frame.hdr0;
      end else begin
        verdict.status = ST_REPAIR_FAIL;
      end

      if (header_ok) begin
        data_sum = ((kind == RK_INSERTED) ? frame.sum_from_two : frame.sum_from_three)
                   + data_byte;
        verdict.status       = (data_sum == 8'd0) ? ST_OK : ST_DATA_BAD;
        verdict.net_function = nf_byte[7:2];
        verdict.is_response  = nf_byte[2];
        verdict.repair_kind  = kind;
        if (kind == RK_INSERTED) begin
          verdict.frame_length = (cnt >= 9'd255) ? 8'd255 : 8'(cnt + 9'd1);
        end
      end
    end
  end

endmodule

### rtl/ipmb_frame_validator_core.sv
// IPMB frame validator top level: input register, frame state, verdict logic
// and result register. Depends on ipmbv_pkg, ipmbv_accum and ipmbv_verdict.
// A verdict is loaded into the result register when its last byte leaves the input register.
// Throughput: one byte per cycle; a last byte waits in the input register
// only while the result register holds a verdict that is not taken.
// Reset clears the frame state, both valid flags and sets own_address to 16.
module ipmb_frame_validator_core
  import ipmbv_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  logic          byte_valid,
  output logic          byte_stall,
  input  byte_item_t    byte_item,
  output logic          verdict_valid,
  input  logic          verdict_stall,
  output verdict_item_t verdict_item,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [6:0]    cfg_data
);

  logic          s1_valid;
  byte_item_t    s1_item;
  logic          s1_adv;
  logic          byte_accept;
  logic          result_load;
  logic [6:0]    own_address;
  frame_state_t  frame;
  verdict_item_t verdict_comb;

  // A last byte can only move on when the result register is free or emptying.
  assign s1_adv      = !(s1_item.last_byte && verdict_valid && verdict_stall);
  assign byte_stall  = s1_valid && !s1_adv;
  assign byte_accept = byte_valid && !byte_stall;
  assign result_load = s1_valid && s1_item.last_byte && s1_adv;
  assign cfg_ready   = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      own_address <= OWN_ADDRESS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      own_address <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (byte_accept) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_accept) begin
      s1_item <= byte_item;
    end
  end

  ipmbv_accum u_accum (
    .clk   (clk),
    .rst   (rst),
    .step  (s1_valid && s1_adv),
    .item  (s1_item),
    .frame (frame)
  );

  ipmbv_verdict u_verdict (
    .frame       (frame),
    .data_byte   (s1_item.data_byte),
    .own_address (own_address),
    .verdict     (verdict_comb)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      verdict_valid <= 1'b0;
    end else if (result_load) begin
      verdict_valid <= 1'b1;
    end else if (!verdict_stall) begin
      verdict_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (result_load) begin
      verdict_item <= verdict_comb;
    end
  end

  a_stall_only_on_last: assert property (@(posedge clk) disable iff (rst)
    byte_stall |-> (s1_valid && s1_item.last_byte && verdict_valid))
    else $error("Input stalled without a pending last byte.");

  a_last_gives_verdict: assert property (@(posedge clk) disable iff (rst)
    result_load |=> verdict_valid)
    else $error("Last byte did not produce a verdict.");

  a_frame_cleared: assert property (@(posedge clk) disable iff (rst)
    result_load |=> (frame.byte_count == 9'd0))
    else $error("Frame state not cleared after last byte.");

  a_reject_fields: assert property (@(posedge clk) disable iff (rst)
    (verdict_valid && (verdict_item.status == ST_OVERSIZE ||
                       verdict_item.status == ST_TOO_SHORT))
    |-> (verdict_item.repair_kind == RK_NONE && verdict_item.net_function == 6'd0))
    else $error("Rejected frame carries header fields.");

endmodule
